[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the job scheduler.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, cond, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

[rtl/core/psjf_pkg.sv]
// Package of the job scheduler: fixed field widths and the controller states.
// No dependencies.
package psjf_pkg;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int NUM_W   = 5;
	localparam int TIME_W  = 20;
	localparam int WTOT_W  = 24;
	localparam int TTOT_W  = 25;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_LOAD  = 7'b0000100,
		S_CMP   = 7'b0001000,
		S_EMIT  = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;
endpackage

[rtl/core/psjf_if.sv]
// Handshake channels of the job scheduler: job items in, schedule items out.
// Depends on psjf_pkg for the field widths.
interface psjf_in_if;
	logic                          valid;
	logic                          ready;
	logic [psjf_pkg::BURST_W-1:0]  burst_len;
	logic [psjf_pkg::PRIO_W-1:0]   job_priority;
	logic                          batch_end;
	modport source (output valid, burst_len, job_priority, batch_end, input ready);
	modport sink (input valid, burst_len, job_priority, batch_end, output ready);
endinterface

interface psjf_out_if;
	logic                          valid;
	logic                          ready;
	logic [psjf_pkg::NUM_W-1:0]    job_number;
	logic [psjf_pkg::PRIO_W-1:0]   out_priority;
	logic [psjf_pkg::BURST_W-1:0]  out_burst;
	logic [psjf_pkg::TIME_W-1:0]   wait_time;
	logic [psjf_pkg::TIME_W-1:0]   turnaround;
	logic [psjf_pkg::TIME_W-1:0]   mean_wait;
	logic [psjf_pkg::TIME_W-1:0]   mean_turnaround;
	logic                          final_job;
	modport source (output valid, job_number, out_priority, out_burst, wait_time,
		turnaround, mean_wait, mean_turnaround, final_job, input ready);
	modport sink (input valid, job_number, out_priority, out_burst, wait_time,
		turnaround, mean_wait, mean_turnaround, final_job, output ready);
endinterface

[rtl/core/priority_sjf_batch_scheduler_unit.sv]
// Top level of the batch job scheduler (priority order, shorter burst on ties).
// Depends on psjf_pkg, the channels in psjf_if.sv and assert_macros.svh.
//
// Usage: job items enter on job_in, one per cycle while the block is loading.
// Each job is numbered from 1 in arrival order; jobs beyond MAX_JOBS are
// dropped. The item with batch_end set closes the batch and job_in.ready
// falls until the whole schedule has been delivered on sched_out.
// The jobs sit in one memory with a registered read. For each position j of the
// exchange sort the block fetches entry j and loads it, then for each later entry
// reads it and compares it, with a possible write-back, and finally forms the
// item. After the final item is formed, a bit-serial divider forms both means
// before that item is offered. Each scheduled item is held in the output register
// until taken, so a stalled receiver simply stops the scan.
// Reset empties the batch; the job memory itself is not cleared since only
// entries written in the current batch are ever read.
module priority_sjf_batch_scheduler_unit #(
	parameter int MAX_JOBS      = 16,
	parameter int BURST_BITS    = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	psjf_in_if.sink           job_in,
	psjf_out_if.source        sched_out
);
	import psjf_pkg::*;

	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int DIV_STEPS = TTOT_W;
	localparam int DCNT_W = $clog2(DIV_STEPS + 1);

	// An entry packs the sort key (priority above burst) over the arrival number,
	// so a plain compare of the upper bits gives the key order.
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [BURST_BITS-1:0]    burst;
		logic [CNT_W-1:0]         num;
	} entry_t;

	// Job memory: one write port, one registered read port.
	entry_t mem [MAX_JOBS];
	entry_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	entry_t           cur_q;
	logic [TTOT_W-1:0] run_q;
	logic [WTOT_W-1:0] wtot_q;
	logic [TTOT_W-1:0] ttot_q;
	logic [TTOT_W-1:0] dw_q;
	logic [TTOT_W-1:0] dt_q;
	logic [CNT_W-1:0]  rw_q;
	logic [CNT_W-1:0]  rt_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [NUM_W-1:0]   o_num_q;
	logic [PRIO_W-1:0]  o_prio_q;
	logic [BURST_W-1:0] o_burst_q;
	logic [TIME_W-1:0]  o_wait_q;
	logic [TIME_W-1:0]  o_tat_q;
	logic [TIME_W-1:0]  o_mw_q;
	logic [TIME_W-1:0]  o_mt_q;
	logic               o_final_q;

	// Field width adaptation, through a 32-bit zero extension.
	logic [31:0] burst_in32, prio_in32, cur_burst32, cur_prio32, cur_num32;
	logic [CNT_W-1:0] k_next;
	logic [CNT_W-1:0] last_j;
	logic             accept_in, store_job, swap;
	logic [TTOT_W-1:0] t_sum;
	logic [WTOT_W-1:0] wtot_sum;
	logic [TTOT_W-1:0] ttot_sum;
	logic [CNT_W:0]   shw, sht, subw, subt;
	logic             gew, get;

	assign burst_in32  = {16'd0, job_in.burst_len};
	assign prio_in32   = {24'd0, job_in.job_priority};
	assign cur_burst32 = 32'(cur_q.burst);
	assign cur_prio32  = 32'(cur_q.prio);
	assign cur_num32   = 32'(cur_q.num);

	assign accept_in = job_in.valid && job_in.ready;
	assign store_job = accept_in && (count_q < CNT_W'(MAX_JOBS));
	assign k_next    = k_q + CNT_W'(1);
	assign last_j    = n_q - CNT_W'(1);
	// The entry at position j moves down whenever its key is strictly greater.
	assign swap      = (state_q == S_CMP) &&
		({cur_q.prio, cur_q.burst} > {rd_q.prio, rd_q.burst});

	assign t_sum    = run_q + cur_burst32[TTOT_W-1:0];
	assign wtot_sum = wtot_q + run_q[WTOT_W-1:0];
	assign ttot_sum = ttot_q + t_sum;

	// One restoring division step for each of the two means.
	assign shw  = {rw_q, dw_q[TTOT_W-1]};
	assign sht  = {rt_q, dt_q[TTOT_W-1]};
	assign gew  = shw >= {1'b0, n_q};
	assign get  = sht >= {1'b0, n_q};
	assign subw = shw - {1'b0, n_q};
	assign subt = sht - {1'b0, n_q};

	always_comb begin
		unique case (state_q)
			S_FETCH: rd_addr = j_q[IDX_W-1:0];
			S_LOAD:  rd_addr = k_q[IDX_W-1:0];
			S_CMP:   rd_addr = k_next[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data.prio  = prio_in32[PRIORITY_BITS-1:0];
		wr_data.burst = burst_in32[BURST_BITS-1:0];
		wr_data.num   = count_q + CNT_W'(1);
		if (store_job) begin
			wr_en = 1'b1;
		end else if (swap) begin
			wr_en   = 1'b1;
			wr_addr = k_q[IDX_W-1:0];
			wr_data = cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wtot_q  <= '0;
			ttot_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						if (store_job) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (job_in.batch_end) begin
							n_q     <= store_job ? count_q + CNT_W'(1) : count_q;
							j_q     <= '0;
							run_q   <= '0;
							wtot_q  <= '0;
							ttot_q  <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					k_q     <= j_q + CNT_W'(1);
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cur_q   <= rd_q;
					state_q <= (k_q < n_q) ? S_CMP : S_EMIT;
				end
				S_CMP: begin
					if (swap) begin
						cur_q <= rd_q;
					end
					k_q     <= k_next;
					state_q <= (k_next < n_q) ? S_CMP : S_EMIT;
				end
				S_EMIT: begin
					o_num_q   <= cur_num32[NUM_W-1:0];
					o_prio_q  <= cur_prio32[PRIO_W-1:0];
					o_burst_q <= cur_burst32[BURST_W-1:0];
					o_wait_q  <= run_q[TIME_W-1:0];
					o_tat_q   <= t_sum[TIME_W-1:0];
					o_mw_q    <= '0;
					o_mt_q    <= '0;
					o_final_q <= 1'b0;
					run_q     <= t_sum;
					wtot_q    <= wtot_sum;
					ttot_q    <= ttot_sum;
					if (j_q == last_j) begin
						dw_q    <= {1'b0, wtot_sum};
						dt_q    <= ttot_sum;
						rw_q    <= '0;
						rt_q    <= '0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (dcnt_q == DCNT_W'(DIV_STEPS)) begin
						o_mw_q    <= dw_q[TIME_W-1:0];
						o_mt_q    <= dt_q[TIME_W-1:0];
						o_final_q <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						rw_q   <= gew ? subw[CNT_W-1:0] : shw[CNT_W-1:0];
						rt_q   <= get ? subt[CNT_W-1:0] : sht[CNT_W-1:0];
						dw_q   <= {dw_q[TTOT_W-2:0], gew};
						dt_q   <= {dt_q[TTOT_W-2:0], get};
						dcnt_q <= dcnt_q + DCNT_W'(1);
					end
				end
				S_OUT: begin
					if (sched_out.ready) begin
						if (o_final_q) begin
							count_q <= '0;
							wtot_q  <= '0;
							ttot_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign job_in.ready              = (state_q == S_IDLE);
	assign sched_out.valid           = (state_q == S_OUT);
	assign sched_out.job_number      = o_num_q;
	assign sched_out.out_priority    = o_prio_q;
	assign sched_out.out_burst       = o_burst_q;
	assign sched_out.wait_time       = o_wait_q;
	assign sched_out.turnaround      = o_tat_q;
	assign sched_out.mean_wait       = o_mw_q;
	assign sched_out.mean_turnaround = o_mt_q;
	assign sched_out.final_job       = o_final_q;

`include "assert_macros.svh"
	`ASSERT_NEVER(a_in_out_excl, job_in.ready && sched_out.valid)
	`ASSERT_NEVER(a_count_range, count_q > CNT_W'(MAX_JOBS))
	`ASSERT_IMPLIES(a_scan_range, state_q == S_CMP, k_q < n_q && n_q != '0)
	`ASSERT_IMPLIES(a_means_final, sched_out.valid && !sched_out.final_job,
		sched_out.mean_wait == '0 && sched_out.mean_turnaround == '0)
endmodule
